[hdl/brainfuck_loop_detector_top_macros.svh]
// Assertion macros used by the checker file of the loop detector.
`ifndef BRAINFUCK_LOOP_DETECTOR_TOP_MACROS_SVH
`define BRAINFUCK_LOOP_DETECTOR_TOP_MACROS_SVH
// Checked property with reset masking.
`define BFLD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds while reset is applied.
`define BFLD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hdl/bfld_pkg.sv]
// Package with shared types and constants of the loop detector.
package bfld_pkg;

  localparam int unsigned TAPE_DEPTH_DEF    = 131072;
  localparam int unsigned PROGRAM_DEPTH_DEF = 4096;
  localparam int unsigned INPUT_DEPTH_DEF   = 4096;

  localparam int unsigned TAPE_SIZE_W  = 18;
  localparam int unsigned STEP_W       = 28;
  localparam int unsigned INDEX_W      = 12;
  localparam int unsigned CFG_DATA_W   = 28;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [TAPE_SIZE_W-1:0] TAPE_SIZE_RESET  = 18'd131072;
  localparam logic [STEP_W-1:0]      STEP_LIMIT_RESET = 28'd50000000;
  localparam logic [STEP_W-1:0]      STEPS_MAX        = {STEP_W{1'b1}};
  localparam logic [7:0]             CELL_PAST_END    = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    KIND_PROG  = 2'd0,
    KIND_INPUT = 2'd1,
    KIND_RUN   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    SYM_PLUS  = 3'd0,
    SYM_MINUS = 3'd1,
    SYM_LEFT  = 3'd2,
    SYM_RIGHT = 3'd3,
    SYM_OPEN  = 3'd4,
    SYM_CLOSE = 3'd5,
    SYM_OUT   = 3'd6,
    SYM_IN    = 3'd7
  } sym_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP,
    ST_LINK,
    ST_CLEAR,
    ST_FETCH,
    ST_EXEC,
    ST_MATE,
    ST_LOOPRES,
    ST_REPORT
  } ctrl_state_e;

  typedef struct packed {
    logic               status;
    logic [INDEX_W-1:0] loop_open_index;
    logic [INDEX_W-1:0] loop_close_index;
    logic [STEP_W-1:0]  steps_taken;
  } result_t;

endpackage

[hdl/bfld_if.sv]
// Valid/ready channel interfaces for input and result items.
interface bfld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] symbol;
  logic [7:0] data_byte;
  modport source (output valid, kind, symbol, data_byte, input ready);
  modport sink (input valid, kind, symbol, data_byte, output ready);
endinterface

interface bfld_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [11:0] loop_open_index;
  logic [11:0] loop_close_index;
  logic [27:0] steps_taken;
  modport source (output valid, status, loop_open_index, loop_close_index, steps_taken,
                  input ready);
  modport sink (input valid, status, loop_open_index, loop_close_index, steps_taken,
                output ready);
endinterface

[hdl/brainfuck_loop_detector_top.sv]
// Top level of the tape machine with endless-loop detection.
// Load items (kind 0 program symbol, kind 1 input byte) are taken one per cycle, except a
// close bracket that finds an open partner, which passes through the pop and link states
// because the partner index is popped from the bracket stack memory and both program
// entries are then written through the single write port of the program store. A run item
// first clears the tape with one write per cycle over the configured tape size (after
// clamping to 1..TAPE_DEPTH), then executes each command in a fetch state, which reads the
// program entry, the tape cell and the next input byte from their memories, and an exec
// state, which updates the cell and the counters. A loop report passes through the mate
// and loopres states to fetch the partner of the outermost open bracket. The single
// result lands in an output register; while it waits there, load items are accepted
// again. A run that reaches the step limit at a matched open bracket reports status 1 and
// the bracket pair of the outermost loop still in progress; otherwise status 0 with zero
// indices. The step count saturates at its maximum. Configuration (tape_size, step_limit)
// is written through a plain write port and may only change while no item is in progress.
module brainfuck_loop_detector_top
  import bfld_pkg::*;
#(
  parameter int unsigned TAPE_DEPTH    = TAPE_DEPTH_DEF,
  parameter int unsigned PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
  parameter int unsigned INPUT_DEPTH   = INPUT_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bfld_in_if.sink               in_i,
  bfld_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned TW  = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam int unsigned IW  = $clog2(PROGRAM_DEPTH);
  localparam int unsigned NW  = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int unsigned PEW = IW + 4;

  // Configuration registers.
  logic [TAPE_SIZE_W-1:0] tape_size_q;
  logic [STEP_W-1:0]      step_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_size_q  <= TAPE_SIZE_RESET;
      step_limit_q <= STEP_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TAPE_SIZE:  tape_size_q  <= cfg_data_i[TAPE_SIZE_W-1:0];
        CFG_STEP_LIMIT: step_limit_q <= cfg_data_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Memory ports driven by the sequencer.
  logic           p_we, s_we, i_we, t_we;
  logic [IW-1:0]  p_waddr, p_raddr, s_waddr, s_raddr, s_wdata, s_rdata;
  logic [PEW-1:0] p_wdata, p_rdata;
  logic [NW-1:0]  i_waddr, i_raddr;
  logic [7:0]     i_wdata, i_rdata, t_wdata, t_rdata;
  logic [TW-1:0]  t_waddr, t_raddr;

  logic    res_valid, res_ready;
  result_t res;

  bfld_ctrl #(
    .TAPE_DEPTH   (TAPE_DEPTH),
    .PROGRAM_DEPTH(PROGRAM_DEPTH),
    .INPUT_DEPTH  (INPUT_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .tape_size_i (tape_size_q),
    .step_limit_i(step_limit_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .p_we_o      (p_we),
    .p_waddr_o   (p_waddr),
    .p_wdata_o   (p_wdata),
    .p_raddr_o   (p_raddr),
    .p_rdata_i   (p_rdata),
    .s_we_o      (s_we),
    .s_waddr_o   (s_waddr),
    .s_wdata_o   (s_wdata),
    .s_raddr_o   (s_raddr),
    .s_rdata_i   (s_rdata),
    .i_we_o      (i_we),
    .i_waddr_o   (i_waddr),
    .i_wdata_o   (i_wdata),
    .i_raddr_o   (i_raddr),
    .i_rdata_i   (i_rdata),
    .t_we_o      (t_we),
    .t_waddr_o   (t_waddr),
    .t_wdata_o   (t_wdata),
    .t_raddr_o   (t_raddr),
    .t_rdata_i   (t_rdata)
  );

  // Program store: symbol, matched flag and partner index per entry.
  bfld_ram #(.WIDTH(PEW), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk_i(clk_i), .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  // Bracket stack of open bracket indices.
  bfld_ram #(.WIDTH(IW), .DEPTH(PROGRAM_DEPTH)) u_stack (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // Input byte buffer.
  bfld_ram #(.WIDTH(8), .DEPTH(INPUT_DEPTH)) u_inbuf (
    .clk_i(clk_i), .we_i(i_we), .waddr_i(i_waddr), .wdata_i(i_wdata),
    .raddr_i(i_raddr), .rdata_o(i_rdata)
  );

  // Tape cells. A write lands before the next read of the same cell is issued.
  bfld_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk_i(clk_i), .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  // Output register: the finished result waits here so loads can proceed.
  logic    out_valid_q;
  result_t out_q;

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_q.status;
  assign out_o.loop_open_index  = out_q.loop_open_index;
  assign out_o.loop_close_index = out_q.loop_close_index;
  assign out_o.steps_taken      = out_q.steps_taken;

endmodule

[hdl/bfld_ram.sv]
// Simple dual-port synchronous RAM with a registered read port.
module bfld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/bfld_ctrl.sv]
// Sequencer for program loading, bracket linking, tape clearing and execution.
module bfld_ctrl
  import bfld_pkg::*;
#(
  parameter int unsigned TAPE_DEPTH    = TAPE_DEPTH_DEF,
  parameter int unsigned PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
  parameter int unsigned INPUT_DEPTH   = INPUT_DEPTH_DEF,
  localparam int unsigned TW  = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1,
  localparam int unsigned IW  = $clog2(PROGRAM_DEPTH),
  localparam int unsigned NW  = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1,
  localparam int unsigned PEW = IW + 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bfld_in_if.sink                in_i,
  input  logic [TAPE_SIZE_W-1:0] tape_size_i,
  input  logic [STEP_W-1:0]      step_limit_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output result_t                res_o,
  output logic                   p_we_o,
  output logic [IW-1:0]          p_waddr_o,
  output logic [PEW-1:0]         p_wdata_o,
  output logic [IW-1:0]          p_raddr_o,
  input  logic [PEW-1:0]         p_rdata_i,
  output logic                   s_we_o,
  output logic [IW-1:0]          s_waddr_o,
  output logic [IW-1:0]          s_wdata_o,
  output logic [IW-1:0]          s_raddr_o,
  input  logic [IW-1:0]          s_rdata_i,
  output logic                   i_we_o,
  output logic [NW-1:0]          i_waddr_o,
  output logic [7:0]             i_wdata_o,
  output logic [NW-1:0]          i_raddr_o,
  input  logic [7:0]             i_rdata_i,
  output logic                   t_we_o,
  output logic [TW-1:0]          t_waddr_o,
  output logic [7:0]             t_wdata_o,
  output logic [TW-1:0]          t_raddr_o,
  input  logic [7:0]             t_rdata_i
);

  ctrl_state_e state_q, state_d;
  logic [IW:0]   prog_len_q, prog_len_d;
  logic [NW:0]   in_len_q, in_len_d;
  logic [IW:0]   sdepth_q, sdepth_d;
  logic [IW:0]   pc_q, pc_d;
  logic [TW-1:0] ptr_q, ptr_d;
  logic [NW:0]   in_pos_q, in_pos_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic          ov_q, ov_d;
  logic [IW-1:0] outer_q, outer_d;
  logic [TW:0]   size_q, size_d;
  logic [TW-1:0] clr_q, clr_d;
  logic [IW-1:0] at_q, at_d;
  logic [IW-1:0] open_q, open_d;
  result_t       res_q, res_d;

  logic [31:0]   ts32;
  logic [31:0]   outer32;
  logic [31:0]   mate32;
  logic [2:0]    e_sym;
  logic          e_matched;
  logic [IW-1:0] e_mate;
  logic [STEP_W-1:0] steps_n;
  logic [TW:0]   ptr_inc;
  logic [IW-1:0] at_w;

  assign ts32      = 32'(tape_size_i);
  assign outer32   = 32'(outer_q);
  assign mate32    = 32'(p_rdata_i[IW-1:0]);
  assign e_sym     = p_rdata_i[IW+3:IW+1];
  assign e_matched = p_rdata_i[IW];
  assign e_mate    = p_rdata_i[IW-1:0];
  assign steps_n   = (steps_q == STEPS_MAX) ? steps_q : steps_q + 1'b1;
  assign ptr_inc   = {1'b0, ptr_q} + 1'b1;
  assign at_w      = prog_len_q[IW-1:0];

  assign res_o       = res_q;
  assign res_valid_o = (state_q == ST_REPORT);
  assign in_i.ready  = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      prog_len_q <= '0;
      in_len_q   <= '0;
      sdepth_q   <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      prog_len_q <= prog_len_d;
      in_len_q   <= in_len_d;
      sdepth_q   <= sdepth_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q     <= pc_d;
    ptr_q    <= ptr_d;
    in_pos_q <= in_pos_d;
    steps_q  <= steps_d;
    outer_q  <= outer_d;
    size_q   <= size_d;
    clr_q    <= clr_d;
    at_q     <= at_d;
    open_q   <= open_d;
    res_q    <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    prog_len_d = prog_len_q;
    in_len_d   = in_len_q;
    sdepth_d   = sdepth_q;
    pc_d       = pc_q;
    ptr_d      = ptr_q;
    in_pos_d   = in_pos_q;
    steps_d    = steps_q;
    ov_d       = ov_q;
    outer_d    = outer_q;
    size_d     = size_q;
    clr_d      = clr_q;
    at_d       = at_q;
    open_d     = open_q;
    res_d      = res_q;
    p_we_o     = 1'b0;
    p_waddr_o  = at_w;
    p_wdata_o  = {in_i.symbol, 1'b0, {IW{1'b0}}};
    p_raddr_o  = pc_q[IW-1:0];
    s_we_o     = 1'b0;
    s_waddr_o  = sdepth_q[IW-1:0];
    s_wdata_o  = at_w;
    s_raddr_o  = sdepth_q[IW-1:0] - 1'b1;
    i_we_o     = 1'b0;
    i_waddr_o  = in_len_q[NW-1:0];
    i_wdata_o  = in_i.data_byte;
    i_raddr_o  = in_pos_q[NW-1:0];
    t_we_o     = 1'b0;
    t_waddr_o  = ptr_q;
    t_wdata_o  = t_rdata_i;
    t_raddr_o  = ptr_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          case (in_i.kind)
            KIND_PROG: begin
              if (prog_len_q < (IW+1)'(PROGRAM_DEPTH)) begin
                prog_len_d = prog_len_q + 1'b1;
                if (in_i.symbol == SYM_CLOSE && sdepth_q != '0) begin
                  // The partner index comes from the stack in the pop state that follows.
                  sdepth_d = sdepth_q - 1'b1;
                  at_d     = at_w;
                  state_d  = ST_POP;
                end else begin
                  p_we_o = 1'b1;
                  if (in_i.symbol == SYM_OPEN) begin
                    s_we_o   = 1'b1;
                    sdepth_d = sdepth_q + 1'b1;
                  end
                end
              end
            end
            KIND_INPUT: begin
              if (in_len_q < (NW+1)'(INPUT_DEPTH)) begin
                i_we_o   = 1'b1;
                in_len_d = in_len_q + 1'b1;
              end
            end
            KIND_RUN: begin
              if (ts32 == 32'd0) begin
                size_d = (TW+1)'(1);
              end else if (ts32 > TAPE_DEPTH) begin
                size_d = (TW+1)'(TAPE_DEPTH);
              end else begin
                size_d = (TW+1)'(ts32);
              end
              clr_d    = '0;
              pc_d     = '0;
              ptr_d    = '0;
              in_pos_d = '0;
              steps_d  = '0;
              ov_d     = 1'b0;
              state_d  = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        p_we_o    = 1'b1;
        p_waddr_o = at_q;
        p_wdata_o = {SYM_CLOSE, 1'b1, s_rdata_i};
        open_d    = s_rdata_i;
        state_d   = ST_LINK;
      end
      ST_LINK: begin
        p_we_o    = 1'b1;
        p_waddr_o = open_q;
        p_wdata_o = {SYM_OPEN, 1'b1, at_q};
        state_d   = ST_IDLE;
      end
      ST_CLEAR: begin
        t_we_o    = 1'b1;
        t_waddr_o = clr_q;
        t_wdata_o = 8'd0;
        if ({1'b0, clr_q} == size_q - 1'b1) begin
          state_d = ST_FETCH;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_FETCH: begin
        if (pc_q >= prog_len_q) begin
          res_d.status           = 1'b0;
          res_d.loop_open_index  = '0;
          res_d.loop_close_index = '0;
          res_d.steps_taken      = steps_q;
          state_d                = ST_REPORT;
        end else begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        steps_d = steps_n;
        pc_d    = pc_q + 1'b1;
        state_d = ST_FETCH;
        case (e_sym)
          SYM_PLUS: begin
            t_we_o    = 1'b1;
            t_wdata_o = t_rdata_i + 8'd1;
          end
          SYM_MINUS: begin
            t_we_o    = 1'b1;
            t_wdata_o = t_rdata_i - 8'd1;
          end
          SYM_LEFT: begin
            ptr_d = (ptr_q == '0) ? TW'(size_q - 1'b1) : ptr_q - 1'b1;
          end
          SYM_RIGHT: begin
            ptr_d = (ptr_inc >= size_q) ? '0 : ptr_inc[TW-1:0];
          end
          SYM_OPEN: begin
            if (e_matched) begin
              if (!ov_q) begin
                ov_d    = 1'b1;
                outer_d = pc_q[IW-1:0];
              end
              if (steps_n >= step_limit_i) begin
                pc_d    = pc_q;
                state_d = ST_MATE;
              end else if (t_rdata_i == 8'd0) begin
                pc_d = {1'b0, e_mate};
              end
            end
          end
          SYM_CLOSE: begin
            if (e_matched) begin
              if (t_rdata_i != 8'd0) begin
                pc_d = {1'b0, e_mate};
              end else if (ov_q && outer_q == e_mate) begin
                ov_d = 1'b0;
              end
            end
          end
          SYM_IN: begin
            t_we_o = 1'b1;
            if (in_pos_q < in_len_q) begin
              t_wdata_o = i_rdata_i;
              in_pos_d  = in_pos_q + 1'b1;
            end else begin
              t_wdata_o = CELL_PAST_END;
            end
          end
          default: begin
          end
        endcase
      end
      ST_MATE: begin
        p_raddr_o = outer_q;
        state_d   = ST_LOOPRES;
      end
      ST_LOOPRES: begin
        res_d.status           = 1'b1;
        res_d.loop_open_index  = outer32[INDEX_W-1:0];
        res_d.loop_close_index = mate32[INDEX_W-1:0];
        res_d.steps_taken      = steps_q;
        state_d                = ST_REPORT;
      end
      ST_REPORT: begin
        if (res_ready_i) begin
          prog_len_d = '0;
          in_len_d   = '0;
          sdepth_d   = '0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/bfld_checker.sv]
// Port-level checker for the loop detector and its bind statement.
`include "brainfuck_loop_detector_top_macros.svh"

module bfld_checker
  import bfld_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic [11:0] out_open,
  input logic [11:0] out_close,
  input logic [27:0] out_steps
);

  `BFLD_ASSERT_NR(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid, "result during reset")
  `BFLD_ASSERT(a_result_held, clk_i, rst_ni, out_valid && !out_ready |=> out_valid, "result dropped")
  `BFLD_ASSERT(a_run_busy, clk_i, rst_ni, in_valid && in_ready && in_kind == KIND_RUN |=> !in_ready, "ready right after run item")
  `BFLD_ASSERT(a_term_zero_idx, clk_i, rst_ni, out_valid && !out_status |-> out_open == 12'd0 && out_close == 12'd0, "terminated run with loop indices")
  `BFLD_ASSERT(a_loop_has_steps, clk_i, rst_ni, out_valid && out_status |-> out_steps != 28'd0, "loop reported without steps")

endmodule

bind brainfuck_loop_detector_top bfld_checker u_bfld_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_kind   (in_i.kind),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_status(out_o.status),
  .out_open  (out_o.loop_open_index),
  .out_close (out_o.loop_close_index),
  .out_steps (out_o.steps_taken)
);

[dv/tb.sv]
// Self-checking testbench for the loop detector top level.
`timescale 1ns / 1ps

module tb;
  import bfld_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned LONG_SYMBOLS = 40;
  localparam int unsigned ITEM_TARGET = 400;
  localparam int unsigned QUIET_FROM = 340;

  typedef enum logic { ACT_CFG, ACT_ITEM } act_e;

  // One row of the directed plan: either a register write or an input item.
  // Rows with typed set carry a result that is obvious from the spec.
  typedef struct {
    act_e            act;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [1:0]      kind;
    logic [2:0]      sym;
    logic [7:0]      byte_v;
    bit              typed;
    result_t         res;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bfld_in_if  in_if ();
  bfld_out_if out_if ();

  brainfuck_loop_detector_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Shadow copy of the machine: stores, lengths and the two registers.
  logic [7:0]  tape_mem [TAPE_DEPTH_DEF];
  sym_e        prog_sym [PROGRAM_DEPTH_DEF];
  bit          prog_matched [PROGRAM_DEPTH_DEF];
  int unsigned prog_mate [PROGRAM_DEPTH_DEF];
  int unsigned open_stack [PROGRAM_DEPTH_DEF];
  logic [7:0]  in_bytes [INPUT_DEPTH_DEF];
  int unsigned prog_len, in_len, open_depth;
  logic [TAPE_SIZE_W-1:0] tape_size_q;
  logic [STEP_W-1:0]      step_limit_q;

  result_t pending_runs[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned runs_seen;
  int unsigned cycles;
  bit idle_on;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d (run %0d)", what, got, want, runs_seen);
    mismatches++;
  endtask

  // Appends a program symbol and matches brackets as they arrive.
  function automatic void load_symbol(logic [2:0] s);
    int unsigned at;
    int unsigned op;
    if (prog_len >= PROGRAM_DEPTH_DEF) return;
    at = prog_len;
    prog_len++;
    prog_sym[at] = sym_e'(s);
    prog_matched[at] = 1'b0;
    prog_mate[at] = 0;
    if (sym_e'(s) == SYM_OPEN) begin
      open_stack[open_depth] = at;
      open_depth++;
    end else if (sym_e'(s) == SYM_CLOSE && open_depth > 0) begin
      open_depth--;
      op = open_stack[open_depth];
      prog_matched[at] = 1'b1;
      prog_mate[at] = op;
      prog_matched[op] = 1'b1;
      prog_mate[op] = at;
    end
  endfunction

  // Executes the loaded program and returns the loop verdict.
  function automatic result_t execute_program();
    int unsigned size, ptr, pc, in_pos, outer_idx;
    longint unsigned steps;
    bit looped, outer_ok, jumped;
    result_t r;
    size = tape_size_q;
    if (size < 1) size = 1;
    if (size > TAPE_DEPTH_DEF) size = TAPE_DEPTH_DEF;
    for (int unsigned i = 0; i < size; i++) tape_mem[i] = 8'd0;
    ptr = 0; pc = 0; in_pos = 0; steps = 0;
    looped = 1'b0; outer_ok = 1'b0; outer_idx = 0;
    while (pc < prog_len && !looped) begin
      steps++;
      jumped = 1'b0;
      case (prog_sym[pc])
        SYM_PLUS:  tape_mem[ptr] = tape_mem[ptr] + 8'd1;
        SYM_MINUS: tape_mem[ptr] = tape_mem[ptr] - 8'd1;
        SYM_LEFT:  ptr = (ptr == 0) ? size - 1 : ptr - 1;
        SYM_RIGHT: ptr = (ptr + 1 >= size) ? 0 : ptr + 1;
        SYM_OPEN: begin
          if (prog_matched[pc]) begin
            if (!outer_ok) begin
              outer_idx = pc;
              outer_ok = 1'b1;
            end
            if (steps >= step_limit_q) looped = 1'b1;
            else if (tape_mem[ptr] == 8'd0) begin
              pc = prog_mate[pc];
              jumped = 1'b1;
            end
          end
        end
        SYM_CLOSE: begin
          if (prog_matched[pc]) begin
            if (tape_mem[ptr] != 8'd0) begin
              pc = prog_mate[pc];
              jumped = 1'b1;
            end else if (outer_ok && outer_idx == prog_mate[pc]) begin
              outer_ok = 1'b0;
            end
          end
        end
        SYM_IN: begin
          if (in_pos < in_len) begin
            tape_mem[ptr] = in_bytes[in_pos];
            in_pos++;
          end else begin
            tape_mem[ptr] = CELL_PAST_END;
          end
        end
        default: ;
      endcase
      if (!jumped && !looped) pc++;
    end
    r.status = looped;
    r.loop_open_index  = (looped && outer_ok) ? outer_idx[INDEX_W-1:0] : '0;
    r.loop_close_index = (looped && outer_ok) ? prog_mate[outer_idx][INDEX_W-1:0] : '0;
    r.steps_taken = (steps > STEPS_MAX) ? STEPS_MAX : steps[STEP_W-1:0];
    prog_len = 0;
    in_len = 0;
    open_depth = 0;
    return r;
  endfunction

  // Updates the shadow machine for one accepted input item.
  function automatic void absorb_item(logic [1:0] k, logic [2:0] s, logic [7:0] b,
                                      bit typed, result_t res);
    result_t r;
    case (k)
      KIND_PROG: load_symbol(s);
      KIND_INPUT: begin
        if (in_len < INPUT_DEPTH_DEF) begin
          in_bytes[in_len] = b;
          in_len++;
        end
      end
      KIND_RUN: begin
        r = execute_program();
        pending_runs.push_back(typed ? res : r);
      end
      default: ;
    endcase
  endfunction

  // Sends one item; called at a falling edge and returns at a falling edge.
  task automatic send_item(logic [1:0] k, logic [2:0] s, logic [7:0] b,
                           bit typed = 1'b0, result_t res = '0);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= k;
    in_if.symbol    <= s;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_item(k, s, b, typed, res);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Waits until every expected result is in and the block has gone quiet.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_runs.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TAPE_SIZE) tape_size_q = data[TAPE_SIZE_W-1:0];
    else step_limit_q = data[STEP_W-1:0];
  endtask

  // Random program: mostly balanced brackets, sometimes raw noise.
  // Straight programs never contain brackets, so they end on their own.
  task automatic send_program(int unsigned max_len, bit straight);
    int unsigned len, depth;
    bit noisy;
    logic [2:0] s;
    len = $urandom_range(1, max_len);
    depth = 0;
    noisy = ($urandom_range(0, 4) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(KIND_INPUT, 3'($urandom), 8'($urandom));
      if ($urandom_range(0, 30) == 0)
        send_item(KIND_UNUSED, 3'($urandom), 8'($urandom));
      s = 3'($urandom_range(0, 7));
      if (straight) begin
        while (s == SYM_OPEN || s == SYM_CLOSE) s = 3'($urandom_range(0, 7));
      end else if (!noisy) begin
        if (depth > 0 && $urandom_range(0, 3) == 0) s = SYM_CLOSE;
        else if ($urandom_range(0, 4) == 0) s = SYM_OPEN;
        else while (s == SYM_OPEN || s == SYM_CLOSE) s = 3'($urandom_range(0, 7));
        if (s == SYM_OPEN) depth++;
        if (s == SYM_CLOSE) depth--;
      end
      send_item(KIND_PROG, s, 8'($urandom));
    end
    while (depth > 0) begin
      send_item(KIND_PROG, SYM_CLOSE, 8'd0);
      depth--;
    end
    send_item(KIND_RUN, 3'($urandom), 8'($urandom));
  endtask

  // Result receiver: ready drops for random bursts while idling is on.
  int unsigned stall_left;
  initial out_if.ready = 1'b0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result checker: every accepted result is matched against the oldest run.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      runs_seen++;
      if (pending_runs.size() == 0) begin
        report_mismatch("unexpected result", out_if.steps_taken, 0);
      end else begin
        want = pending_runs.pop_front();
        if (out_if.status !== want.status)
          report_mismatch("status", out_if.status, want.status);
        if (out_if.loop_open_index !== want.loop_open_index)
          report_mismatch("loop_open_index", out_if.loop_open_index, want.loop_open_index);
        if (out_if.loop_close_index !== want.loop_close_index)
          report_mismatch("loop_close_index", out_if.loop_close_index,
                          want.loop_close_index);
        if (out_if.steps_taken !== want.steps_taken)
          report_mismatch("steps_taken", out_if.steps_taken, want.steps_taken);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles,
               pending_runs.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  plan_row_t plan[$];

  initial begin
    plan_row_t row;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_PROG;
    in_if.symbol = SYM_PLUS;
    in_if.data_byte = 8'd0;
    stall_left = 0;
    idle_on = 1'b1;
    mismatches = 0;
    items_sent = 0;
    runs_seen = 0;
    cycles = 0;
    prog_len = 0;
    in_len = 0;
    open_depth = 0;
    tape_size_q = TAPE_SIZE_RESET;
    step_limit_q = STEP_LIMIT_RESET;

    // Directed plan. An empty run right after reset ends at once. With a zero
    // step limit the first matched open bracket reports straight away. The
    // third program hits every command, the cell and pointer wraps on a
    // one-cell tape (size 0 clamps to 1), a read past the input end and both
    // kinds of unmatched bracket. The fourth loops over input bytes 0 and 255.
    // The last one uses an oversized tape (clamped) and reports the outer
    // loop of a nest when the limit falls on the inner bracket.
    plan.push_back('{ACT_ITEM, 0, 0, KIND_RUN, SYM_PLUS, 8'd0, 1, '{0, 0, 0, 0}});
    plan.push_back('{ACT_CFG, CFG_TAPE_SIZE, 28'd0, 0, 0, 0, 0, '0});
    plan.push_back('{ACT_CFG, CFG_STEP_LIMIT, 28'd0, 0, 0, 0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_OPEN, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_CLOSE, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_RUN, SYM_PLUS, 8'd0, 1, '{1, 0, 1, 1}});
    plan.push_back('{ACT_CFG, CFG_STEP_LIMIT, 28'hFFFFFFF, 0, 0, 0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_PLUS, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_MINUS, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_MINUS, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_LEFT, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_RIGHT, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_IN, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_OUT, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_CLOSE, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_OPEN, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_RUN, SYM_PLUS, 8'd0, 1, '{0, 0, 0, 9}});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_INPUT, SYM_PLUS, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_INPUT, SYM_IN, 8'd255, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_UNUSED, SYM_IN, 8'd255, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_IN, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_OPEN, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_MINUS, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_CLOSE, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_IN, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_OPEN, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_MINUS, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_CLOSE, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_RUN, SYM_PLUS, 8'd0, 0, '0});
    plan.push_back('{ACT_CFG, CFG_TAPE_SIZE, 28'h003FFFF, 0, 0, 0, 0, '0});
    plan.push_back('{ACT_CFG, CFG_STEP_LIMIT, 28'd5, 0, 0, 0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_PLUS, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_OPEN, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_OPEN, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_CLOSE, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_PROG, SYM_CLOSE, 8'd0, 0, '0});
    plan.push_back('{ACT_ITEM, 0, 0, KIND_RUN, SYM_PLUS, 8'd0, 1, '{1, 1, 4, 5}});

    // Reset is held from the start and released at a falling edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.act == ACT_CFG) write_reg(row.idx, row.data);
      else send_item(row.kind, row.sym, row.byte_v, row.typed, row.res);
    end

    // A longer straight program on a small tape, with an input byte before every
    // third symbol, so the run walks all of it and can run the input buffer dry.
    write_reg(CFG_TAPE_SIZE, 28'd7);
    write_reg(CFG_STEP_LIMIT, 28'd100);
    for (int unsigned i = 0; i < LONG_SYMBOLS; i++) begin
      if (i % 3 == 0) send_item(KIND_INPUT, 3'($urandom), 8'($urandom));
      send_item(KIND_PROG, ($urandom_range(0, 1) != 0) ? SYM_IN : SYM_RIGHT, 8'd0);
    end
    send_item(KIND_RUN, SYM_PLUS, 8'd0);

    // Random phases with fresh settings; small tapes and limits keep the
    // runs short. Every phase starts after the sender waited for all results.
    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      if (items_sent >= QUIET_FROM) idle_on = 1'b0;
      write_reg(CFG_TAPE_SIZE, 28'($urandom_range(1, 3) == 1 ? 1 : $urandom_range(1, 64)));
      if (ph % 4 == 3) write_reg(CFG_STEP_LIMIT, 28'hFFFFFFF);
      else write_reg(CFG_STEP_LIMIT, 28'($urandom_range(1, 1500)));
      repeat ($urandom_range(1, 2)) send_program(16, ph % 4 == 3);
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Sent %0d items and checked %0d runs over wrapped tapes, nested loops,",
             items_sent, runs_seen);
    $display("limit hits, unmatched brackets and input exhaustion.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[brainfuck_loop_detector_top.f]
+incdir+hdl
hdl/bfld_pkg.sv
hdl/bfld_if.sv
hdl/bfld_ram.sv
hdl/bfld_ctrl.sv
hdl/brainfuck_loop_detector_top.sv
hdl/bfld_checker.sv
dv/tb.sv
